/* rtl/core/srsw_pkg.sv */
// shared types, codes and constants for the selective-repeat send window
// no dependencies; used by srsw_ctrl, srsw_dp and selective_repeat_send_window
package srsw_pkg;

	// most packets tracked by the ack-mark ring
	localparam int unsigned WINDOW_MAX = 32;
	localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	localparam logic [5:0]  WINDOW_RESET  = 6'd8;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] TIMER_SAT     = 16'hffff;

	typedef enum logic [1:0] {
		CMD_SEND = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NOTHING = 2'd0,
		ACT_SEND    = 2'd1,
		ACT_RESEND  = 2'd2,
		ACT_UNUSED  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_DUP_ACK   = 2'd2,
		ST_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_WIN_SIZE      = 2'd0,
		CFG_TIMEOUT_TICKS = 2'd1,
		CFG_RSVD_2        = 2'd2,
		CFG_RSVD_3        = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] ack_number;
	} evt_item_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] seq_to_send;
		logic [1:0]  status;
		logic [31:0] window_base;
		logic [5:0]  in_flight;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic latch_evt;
		logic exec;
		logic slide;
		logic load_res;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ack_taken;
		logic slide_more;
	} dp_status_t;

endpackage

/* rtl/core/srsw_dp.sv */
// datapath: window state, ack-mark ring, timer, config registers and result register
// depends on srsw_pkg; driven by srsw_ctrl through srsw_pkg::dp_cmd_t
module srsw_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srsw_pkg::evt_item_t  evt_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  srsw_pkg::dp_cmd_t    cmd,
	output srsw_pkg::dp_status_t status,
	output srsw_pkg::res_item_t  res_data
);

	localparam logic [31:0] WIN_MAX_W = 32'(srsw_pkg::WINDOW_MAX);

	logic [5:0]  win_size_q;
	logic [15:0] timeout_q;
	logic [31:0] base_q;
	logic [31:0] next_q;
	logic [15:0] timer_q;
	logic [srsw_pkg::WINDOW_MAX-1:0] marks_q;

	logic [1:0]  evt_cmd_q;
	logic [31:0] evt_ack_q;
	logic [1:0]  action_q;
	logic [31:0] seq_q;
	logic [1:0]  status_q;
	srsw_pkg::res_item_t res_q;

	logic [31:0] flight;
	logic [31:0] eff_win;
	logic [31:0] ack_dist;
	logic [31:0] ack_prev;
	logic [16:0] timer_inc;
	logic        send_ok;
	logic        ack_dup;
	logic        ack_beyond;
	logic        tick_fire;
	logic        base_marked;

	assign flight    = next_q - base_q;
	assign ack_dist  = evt_ack_q - base_q;
	assign ack_prev  = evt_ack_q - 32'd1;
	assign timer_inc = {1'b0, timer_q} + 17'd1;

	always_comb begin
		if (win_size_q == 6'd0) begin
			eff_win = 32'd1;
		end else if ({26'd0, win_size_q} > WIN_MAX_W) begin
			eff_win = WIN_MAX_W;
		end else begin
			eff_win = {26'd0, win_size_q};
		end
	end

	assign send_ok     = flight < eff_win;
	assign ack_dup     = (ack_dist == 32'd0) || ack_dist[31];
	assign ack_beyond  = ack_dist > flight;
	assign tick_fire   = (flight != 32'd0) && (timer_inc > {1'b0, timeout_q});
	assign base_marked = marks_q[base_q[srsw_pkg::SLOT_W-1:0]];

	assign status.ack_taken  = (srsw_pkg::cmd_t'(evt_cmd_q) == srsw_pkg::CMD_ACK)
		&& !ack_dup && !ack_beyond;
	assign status.slide_more = (next_q != base_q) && base_marked;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= srsw_pkg::WINDOW_RESET;
			timeout_q  <= srsw_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (srsw_pkg::cfg_idx_t'(cfg_index))
				srsw_pkg::CFG_WIN_SIZE:      win_size_q <= cfg_data[5:0];
				srsw_pkg::CFG_TIMEOUT_TICKS: timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (cmd.latch_evt) begin
			evt_cmd_q <= evt_data.cmd;
			evt_ack_q <= evt_data.ack_number;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			next_q  <= '0;
			timer_q <= '0;
			marks_q <= '0;
		end else if (cmd.exec) begin
			case (srsw_pkg::cmd_t'(evt_cmd_q))
				srsw_pkg::CMD_SEND: begin
					if (send_ok) begin
						if (flight == 32'd0) begin
							timer_q <= '0;
						end
						marks_q[next_q[srsw_pkg::SLOT_W-1:0]] <= 1'b0;
						next_q <= next_q + 32'd1;
					end
				end
				srsw_pkg::CMD_ACK: begin
					if (!ack_dup && !ack_beyond) begin
						timer_q <= '0;
						marks_q[ack_prev[srsw_pkg::SLOT_W-1:0]] <= 1'b1;
					end
				end
				srsw_pkg::CMD_TICK: begin
					if (tick_fire) begin
						timer_q <= '0;
					end else if (timer_inc[16]) begin
						timer_q <= srsw_pkg::TIMER_SAT;
					end else begin
						timer_q <= timer_inc[15:0];
					end
				end
				default: ;
			endcase
		end else if (cmd.slide && status.slide_more) begin
			marks_q[base_q[srsw_pkg::SLOT_W-1:0]] <= 1'b0;
			base_q <= base_q + 32'd1;
		end
	end

	// per-event result fields
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			action_q <= srsw_pkg::ACT_NOTHING;
			seq_q    <= '0;
			status_q <= srsw_pkg::ST_OK;
			case (srsw_pkg::cmd_t'(evt_cmd_q))
				srsw_pkg::CMD_SEND: begin
					if (send_ok) begin
						action_q <= srsw_pkg::ACT_SEND;
						seq_q    <= next_q;
					end else begin
						status_q <= srsw_pkg::ST_FULL;
					end
				end
				srsw_pkg::CMD_ACK: begin
					if (ack_dup) begin
						status_q <= srsw_pkg::ST_DUP_ACK;
					end else if (ack_beyond) begin
						status_q <= srsw_pkg::ST_BEYOND;
					end
				end
				srsw_pkg::CMD_TICK: begin
					if (tick_fire) begin
						action_q <= srsw_pkg::ACT_RESEND;
						seq_q    <= base_q;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_q.action      <= action_q;
			res_q.seq_to_send <= seq_q;
			res_q.status      <= status_q;
			res_q.window_base <= base_q;
			res_q.in_flight   <= flight[5:0];
		end
	end

	assign res_data = res_q;

endmodule

/* rtl/core/srsw_ctrl.sv */
// controller: event sequencing state machine and result valid flag
// depends on srsw_pkg; steers srsw_dp through dp_cmd_t, reads dp_status_t
module srsw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_ready,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  srsw_pkg::dp_status_t status,
	output srsw_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_SLIDE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   res_free;

	assign res_free  = !res_valid_q || res_ready;
	assign evt_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		state_d       = state_q;
		cmd.latch_evt = 1'b0;
		cmd.exec      = 1'b0;
		cmd.slide     = 1'b0;
		cmd.load_res  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (evt_valid) begin
					cmd.latch_evt = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.ack_taken ? S_SLIDE : S_DONE;
			end
			S_SLIDE: begin
				cmd.slide = 1'b1;
				if (!status.slide_more) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/selective_repeat_send_window.sv */
// top level of the selective-repeat send window tracker
// depends on srsw_pkg, srsw_ctrl and srsw_dp
//
// sender-side window tracker for a selective-repeat link. each event transfer on
// evt_* is a send request, an arriving acknowledgement number (sequence plus one)
// or one timer tick, and yields exactly one result transfer on res_*: the action
// (nothing, send new, resend base), the sequence involved, a status (ok, window
// full, duplicate ack, ack beyond what was sent) and the window base and packets
// in flight after the event. events are handled one at a time. a send, tick or
// rejected ack is applied and its result handed to the output register; an
// accepted ack also slides the base past each acked entry, at most WINDOW_MAX
// of them, the slide clearing one ack mark per cycle. the result sits in an
// output register, so a new event is taken while the last result is still
// waiting on res_ready. config writes (index 0 window size, index 1 timeout
// ticks) are taken every cycle and belong between events only; a window size
// of 0 acts as 1 and one above WINDOW_MAX acts as WINDOW_MAX.
module selective_repeat_send_window (
	input  logic                clk,
	input  logic                arst_n,
	// event channel
	input  logic                evt_valid,
	output logic                evt_ready,
	input  srsw_pkg::evt_item_t evt_data,
	// result channel
	output logic                res_valid,
	input  logic                res_ready,
	output srsw_pkg::res_item_t res_data,
	// config write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	srsw_pkg::dp_cmd_t    dp_cmd;
	srsw_pkg::dp_status_t dp_status;

	// config registers never stall
	assign cfg_ready = 1'b1;

	// sequencing: idle, apply event, slide base, hand result to output register
	srsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	// window state, ack marks, timer and result register
	srsw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_data  (evt_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.res_data  (res_data)
	);

endmodule
